// File: sv/gbns_pkg.sv
package gbns_pkg;

	localparam int WINDOW_MAX = 32;
	localparam int WIN_CAP    = (WINDOW_MAX < 32) ? WINDOW_MAX : 32;

	localparam int SEQ_W   = 32;
	localparam int WIN_W   = 6;
	localparam int SLOT_W  = 5;
	localparam int TICK_W  = 16;
	localparam int RETRY_W = 8;
	localparam int KIND_W  = 2;
	localparam int ACT_W   = 3;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	localparam int OUT_SEQ_LSB    = 0;
	localparam int OUT_SLOT_LSB   = OUT_SEQ_LSB + SEQ_W;
	localparam int OUT_BASE_LSB   = OUT_SLOT_LSB + SLOT_W;
	localparam int OUT_FLIGHT_LSB = OUT_BASE_LSB + SEQ_W;
	localparam int OUT_USED       = OUT_FLIGHT_LSB + WIN_W;
	localparam int OUT_DW         = ((OUT_USED + 7) / 8) * 8;

	localparam int MOD_STEPS = 4;
	localparam int MOD_ITERS = SEQ_W / MOD_STEPS;
	localparam int MOD_CNT_W = $clog2(MOD_ITERS);

	localparam logic [WIN_W-1:0]   WINDOW_RST  = WIN_W'(4);
	localparam logic [TICK_W-1:0]  TIMEOUT_RST = TICK_W'(100);
	localparam logic [RETRY_W-1:0] RETRY_RST   = RETRY_W'(10);

	localparam logic [1:0] REG_WINDOW  = 2'd0;
	localparam logic [1:0] REG_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_RETRY   = 2'd2;

	typedef enum logic [KIND_W-1:0] {
		KIND_OFFER  = 2'd0,
		KIND_ACK    = 2'd1,
		KIND_TICK   = 2'd2,
		KIND_FINISH = 2'd3
	} kind_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_NONE    = 3'd0,
		ACT_SEND    = 3'd1,
		ACT_RESEND  = 3'd2,
		ACT_EOF     = 3'd3,
		ACT_DONE    = 3'd4,
		ACT_GAVE_UP = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		PH_DATA   = 2'd0,
		PH_FINISH = 2'd1,
		PH_EOF    = 2'd2,
		PH_ENDED  = 2'd3
	} phase_t;

	typedef struct packed {
		logic [WIN_W-1:0]   window_size;
		logic [TICK_W-1:0]  timeout_ticks;
		logic [RETRY_W-1:0] retry_limit;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic mod_start;
		logic commit;
		logic run_init;
		logic run_emit;
	} cmd_t;

	typedef struct packed {
		logic need_mod;
		logic is_run;
		logic mod_done;
		logic out_space;
		logic run_last;
	} stat_t;

endpackage

// File: sv/gbns_cfg.sv
module gbns_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gbns_pkg::APB_AW-1:0] paddr,
	input  logic [gbns_pkg::APB_DW-1:0] pwdata,
	output logic [gbns_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	output gbns_pkg::cfg_t              cfg
);

	gbns_pkg::cfg_t cfg_q;
	logic [1:0]     idx;

	assign idx    = paddr[gbns_pkg::APB_AW-1:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_size   <= gbns_pkg::WINDOW_RST;
			cfg_q.timeout_ticks <= gbns_pkg::TIMEOUT_RST;
			cfg_q.retry_limit   <= gbns_pkg::RETRY_RST;
		end else if (psel && penable && pwrite) begin
			case (idx)
				gbns_pkg::REG_WINDOW: begin
					cfg_q.window_size <= pwdata[gbns_pkg::WIN_W-1:0];
				end
				gbns_pkg::REG_TIMEOUT: begin
					cfg_q.timeout_ticks <= pwdata[gbns_pkg::TICK_W-1:0];
				end
				gbns_pkg::REG_RETRY: begin
					cfg_q.retry_limit <= pwdata[gbns_pkg::RETRY_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			gbns_pkg::REG_WINDOW: begin
				prdata = gbns_pkg::APB_DW'(cfg_q.window_size);
			end
			gbns_pkg::REG_TIMEOUT: begin
				prdata = gbns_pkg::APB_DW'(cfg_q.timeout_ticks);
			end
			gbns_pkg::REG_RETRY: begin
				prdata = gbns_pkg::APB_DW'(cfg_q.retry_limit);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

// File: sv/gbns_mod.sv
module gbns_mod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [gbns_pkg::SEQ_W-1:0] operand,
	input  logic [gbns_pkg::WIN_W-1:0] divisor,
	output logic                       done,
	output logic [gbns_pkg::WIN_W-1:0] rem
);

	logic                           busy_q;
	logic                           done_q;
	logic [gbns_pkg::SEQ_W-1:0]     dvd_q;
	logic [gbns_pkg::WIN_W-1:0]     rem_q;
	logic [gbns_pkg::MOD_CNT_W-1:0] cnt_q;
	logic [gbns_pkg::WIN_W-1:0]     rem_step;

	assign done = done_q;
	assign rem  = rem_q;

	always_comb begin
		logic [gbns_pkg::WIN_W-1:0] r;
		r = rem_q;
		for (int i = 0; i < gbns_pkg::MOD_STEPS; i++) begin
			r = {r[gbns_pkg::WIN_W-2:0], dvd_q[gbns_pkg::SEQ_W-1-i]};
			if (r >= divisor) begin
				r = r - divisor;
			end
		end
		rem_step = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q && cnt_q == gbns_pkg::MOD_CNT_W'(gbns_pkg::MOD_ITERS - 1)) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= operand;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << gbns_pkg::MOD_STEPS;
			rem_q <= rem_step;
			cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule

// File: sv/gbns_dp.sv
module gbns_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gbns_pkg::cfg_t               cfg,
	input  gbns_pkg::cmd_t               cmd,
	output gbns_pkg::stat_t              stat,
	input  logic [gbns_pkg::KIND_W-1:0]  in_kind,
	input  logic [gbns_pkg::SEQ_W-1:0]   in_ack,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [gbns_pkg::ACT_W-1:0]   out_action,
	output logic [gbns_pkg::SEQ_W-1:0]   out_seq,
	output logic [gbns_pkg::SLOT_W-1:0]  out_slot,
	output logic                         out_last,
	output logic [gbns_pkg::SEQ_W-1:0]   out_base,
	output logic [gbns_pkg::WIN_W-1:0]   out_flight
);

	localparam int SEQ_W   = gbns_pkg::SEQ_W;
	localparam int WIN_W   = gbns_pkg::WIN_W;
	localparam int SLOT_W  = gbns_pkg::SLOT_W;
	localparam int TICK_W  = gbns_pkg::TICK_W;
	localparam int RETRY_W = gbns_pkg::RETRY_W;

	logic [SEQ_W-1:0]   base_q, next_q, ack_q;
	logic [TICK_W-1:0]  elapsed_q;
	logic [RETRY_W-1:0] retries_q;
	gbns_pkg::phase_t   phase_q;
	gbns_pkg::kind_t    kind_q;
	logic               out_valid_q;
	logic [WIN_W-1:0]   run_cnt_q;
	logic [SLOT_W-1:0]  run_slot_q;

	gbns_pkg::action_t  act_q;
	logic [SEQ_W-1:0]   seq_q, obase_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               last_q;
	logic [WIN_W-1:0]   oflight_q;

	logic [WIN_W-1:0]   win;
	logic [SEQ_W-1:0]   flight, ack_off, ack_inc, flight_n, run_seq;
	logic [WIN_W-1:0]   flight_lo;
	logic               in_win;
	logic [TICK_W-1:0]  elapsed_inc;
	logic               expired;
	logic [RETRY_W-1:0] retries_inc;
	logic [WIN_W-1:0]   rem;
	logic               mod_done;
	logic               run_last;
	logic [WIN_W-1:0]   slot_inc;

	gbns_pkg::action_t  act;
	logic [SEQ_W-1:0]   seq, base_n, next_n;
	logic [SLOT_W-1:0]  slot;
	logic [TICK_W-1:0]  elapsed_n;
	logic [RETRY_W-1:0] retries_n;
	gbns_pkg::phase_t   phase_n;
	logic               need_mod, is_run, apply;

	always_comb begin
		win = cfg.window_size;
		if (cfg.window_size == '0) begin
			win = WIN_W'(1);
		end else if (cfg.window_size > WIN_W'(gbns_pkg::WIN_CAP)) begin
			win = WIN_W'(gbns_pkg::WIN_CAP);
		end
	end

	assign flight      = next_q - base_q;
	assign flight_lo   = flight[WIN_W-1:0];
	assign ack_off     = ack_q - base_q;
	assign in_win      = ack_off < flight;
	assign ack_inc     = ack_q + 1'b1;
	assign elapsed_inc = (elapsed_q != '1) ? elapsed_q + 1'b1 : elapsed_q;
	assign expired     = elapsed_inc >= cfg.timeout_ticks;
	assign retries_inc = (retries_q != '1) ? retries_q + 1'b1 : retries_q;
	assign run_last    = (run_cnt_q + 1'b1) == flight_lo;
	assign run_seq     = base_q + SEQ_W'(run_cnt_q);
	assign slot_inc    = {1'b0, run_slot_q} + 1'b1;

	gbns_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mod_start),
		.operand (is_run ? base_q : next_q),
		.divisor (win),
		.done    (mod_done),
		.rem     (rem)
	);

	always_comb begin
		act       = gbns_pkg::ACT_NONE;
		seq       = '0;
		slot      = '0;
		base_n    = base_q;
		next_n    = next_q;
		elapsed_n = elapsed_q;
		retries_n = retries_q;
		phase_n   = phase_q;
		need_mod  = 1'b0;
		is_run    = 1'b0;
		case (kind_q)
			gbns_pkg::KIND_OFFER: begin
				if (phase_q == gbns_pkg::PH_DATA && flight < SEQ_W'(win)) begin
					need_mod = 1'b1;
					act      = gbns_pkg::ACT_SEND;
					seq      = next_q;
					slot     = rem[SLOT_W-1:0];
					next_n   = next_q + 1'b1;
					if (flight == '0) begin
						elapsed_n = '0;
					end
				end
			end
			gbns_pkg::KIND_ACK: begin
				if (phase_q == gbns_pkg::PH_DATA || phase_q == gbns_pkg::PH_FINISH) begin
					if (in_win) begin
						base_n    = ack_inc;
						elapsed_n = '0;
						if (phase_q == gbns_pkg::PH_FINISH && ack_inc == next_q) begin
							phase_n   = gbns_pkg::PH_EOF;
							retries_n = '0;
							act       = gbns_pkg::ACT_EOF;
							seq       = next_q;
						end
					end
				end else if (phase_q == gbns_pkg::PH_EOF) begin
					if (ack_q == next_q) begin
						phase_n = gbns_pkg::PH_ENDED;
						act     = gbns_pkg::ACT_DONE;
					end
				end
			end
			gbns_pkg::KIND_TICK: begin
				if ((phase_q == gbns_pkg::PH_DATA || phase_q == gbns_pkg::PH_FINISH)
				    && flight != '0) begin
					if (expired) begin
						need_mod  = 1'b1;
						is_run    = 1'b1;
						elapsed_n = '0;
					end else begin
						elapsed_n = elapsed_inc;
					end
				end else if (phase_q == gbns_pkg::PH_EOF) begin
					if (expired) begin
						elapsed_n = '0;
						retries_n = retries_inc;
						if (retries_inc >= cfg.retry_limit) begin
							phase_n = gbns_pkg::PH_ENDED;
							act     = gbns_pkg::ACT_GAVE_UP;
						end else begin
							act = gbns_pkg::ACT_EOF;
							seq = next_q;
						end
					end else begin
						elapsed_n = elapsed_inc;
					end
				end
			end
			gbns_pkg::KIND_FINISH: begin
				if (phase_q == gbns_pkg::PH_DATA) begin
					if (flight == '0) begin
						phase_n   = gbns_pkg::PH_EOF;
						retries_n = '0;
						elapsed_n = '0;
						act       = gbns_pkg::ACT_EOF;
						seq       = next_q;
					end else begin
						phase_n = gbns_pkg::PH_FINISH;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign flight_n = next_n - base_n;
	assign apply    = cmd.commit || (cmd.run_emit && run_last);

	assign stat.need_mod  = need_mod;
	assign stat.is_run    = is_run;
	assign stat.mod_done  = mod_done;
	assign stat.out_space = !out_valid_q || out_ready;
	assign stat.run_last  = run_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			next_q      <= '0;
			elapsed_q   <= '0;
			retries_q   <= '0;
			phase_q     <= gbns_pkg::PH_DATA;
			out_valid_q <= 1'b0;
		end else begin
			if (apply) begin
				base_q    <= base_n;
				next_q    <= next_n;
				elapsed_q <= elapsed_n;
				retries_q <= retries_n;
				phase_q   <= phase_n;
			end
			if (cmd.commit || cmd.run_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= gbns_pkg::kind_t'(in_kind);
			ack_q  <= in_ack;
		end
		if (cmd.run_init) begin
			run_cnt_q  <= '0;
			run_slot_q <= rem[SLOT_W-1:0];
		end else if (cmd.run_emit) begin
			run_cnt_q  <= run_cnt_q + 1'b1;
			run_slot_q <= (slot_inc == win || run_seq == '1) ? '0 : slot_inc[SLOT_W-1:0];
		end
		if (cmd.commit) begin
			act_q     <= act;
			seq_q     <= seq;
			slot_q    <= slot;
			last_q    <= 1'b1;
			obase_q   <= base_n;
			oflight_q <= flight_n[WIN_W-1:0];
		end else if (cmd.run_emit) begin
			act_q     <= gbns_pkg::ACT_RESEND;
			seq_q     <= run_seq;
			slot_q    <= run_slot_q;
			last_q    <= run_last;
			obase_q   <= base_q;
			oflight_q <= flight_lo;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_action = act_q;
	assign out_seq    = seq_q;
	assign out_slot   = slot_q;
	assign out_last   = last_q;
	assign out_base   = obase_q;
	assign out_flight = oflight_q;

endmodule

// File: sv/gbns_ctrl.sv
module gbns_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  gbns_pkg::stat_t stat,
	output gbns_pkg::cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EVAL = 5'b00010,
		ST_MOD  = 5'b00100,
		ST_SEND = 5'b01000,
		ST_RUN  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (stat.need_mod) begin
					cmd.mod_start = 1'b1;
					state_d       = ST_MOD;
				end else if (stat.out_space) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_MOD: begin
				if (stat.mod_done) begin
					if (stat.is_run) begin
						cmd.run_init = 1'b1;
						state_d      = ST_RUN;
					end else begin
						state_d = ST_SEND;
					end
				end
			end
			ST_SEND: begin
				if (stat.out_space) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_RUN: begin
				if (stat.out_space) begin
					cmd.run_emit = 1'b1;
					if (stat.run_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: sv/go_back_n_sender_window_core.sv
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  tuser: kind; tdata: ack_seq
// m_*       out        m_tvalid/m_tready  tuser: action; tlast: last;
//                                         tdata: seq, slot, base, in_flight
// apb       in         psel/penable       window_size, timeout_ticks, retry_limit
//
// Ack and finish words, and ticks with no resend, are accepted, then decided and loaded into the output.
// A send takes its slot from a remainder unit that retires
// 4 dividend bits per cycle until all 32 bits are done.
// A timeout resend finds its first slot likewise, then sends each outstanding segment.
// A stalled output holds the block before it loads the next result; one finished
// result may wait in the output register while the next word is accepted.
// Reset clears sequence, timer and phase state; no clearing pass.
module go_back_n_sender_window_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [gbns_pkg::SEQ_W-1:0]   s_tdata,  // ack_seq
	input  logic [gbns_pkg::KIND_W-1:0]  s_tuser,  // kind
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [gbns_pkg::OUT_DW-1:0]  m_tdata,  // seq_number, slot_index, window_base,
	                                               // in_flight, zero pad
	output logic                         m_tlast,
	output logic [gbns_pkg::ACT_W-1:0]   m_tuser,  // action
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gbns_pkg::APB_AW-1:0]  paddr,
	input  logic [gbns_pkg::APB_DW-1:0]  pwdata,
	output logic [gbns_pkg::APB_DW-1:0]  prdata,
	output logic                         pready
);

	gbns_pkg::cfg_t  cfg;
	gbns_pkg::cmd_t  cmd;
	gbns_pkg::stat_t stat;

	logic [gbns_pkg::SEQ_W-1:0]  out_seq, out_base;
	logic [gbns_pkg::SLOT_W-1:0] out_slot;
	logic [gbns_pkg::WIN_W-1:0]  out_flight;

	gbns_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gbns_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gbns_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.stat       (stat),
		.in_kind    (s_tuser),
		.in_ack     (s_tdata),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_action (m_tuser),
		.out_seq    (out_seq),
		.out_slot   (out_slot),
		.out_last   (m_tlast),
		.out_base   (out_base),
		.out_flight (out_flight)
	);

	assign m_tdata = {{(gbns_pkg::OUT_DW - gbns_pkg::OUT_USED){1'b0}},
	                  out_flight, out_base, out_slot, out_seq};

endmodule

// File: sv/gbns_chk.sv
module gbns_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [gbns_pkg::OUT_DW-1:0]  m_tdata,
	input logic                         m_tlast,
	input logic [gbns_pkg::ACT_W-1:0]   m_tuser
);

	logic [gbns_pkg::SLOT_W-1:0] slot;
	logic [gbns_pkg::SEQ_W-1:0]  seq;
	logic [gbns_pkg::WIN_W-1:0]  flight;

	assign seq    = m_tdata[gbns_pkg::OUT_SEQ_LSB +: gbns_pkg::SEQ_W];
	assign slot   = m_tdata[gbns_pkg::OUT_SLOT_LSB +: gbns_pkg::SLOT_W];
	assign flight = m_tdata[gbns_pkg::OUT_FLIGHT_LSB +: gbns_pkg::WIN_W];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("output word changed while stalled");

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while previous word still in work");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != gbns_pkg::ACT_RESEND |-> m_tlast)
		else $error("non-resend result without last");

	a_flight_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> flight <= gbns_pkg::WIN_W'(gbns_pkg::WIN_CAP))
		else $error("in_flight beyond window limit");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == gbns_pkg::ACT_NONE || m_tuser == gbns_pkg::ACT_DONE
		|| m_tuser == gbns_pkg::ACT_GAVE_UP) |-> seq == '0 && slot == '0)
		else $error("sequence or slot set on a result without a segment");

endmodule

bind go_back_n_sender_window_core gbns_chk u_gbns_chk (.*);
